/* design/set_pkg.sv */
`timescale 1ns / 1ps

package set_pkg;

    localparam int CAPACITY    = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int MAX_RESULTS = 32;
    localparam int K_W         = $clog2(MAX_RESULTS + 1);
    localparam int ENTRY_W     = 61;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_DUP       = 3'd1,
        ST_OVERLAP   = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_BAD_TIME  = 3'd5
    } t_status;

    // msb first: sort key is year down to start minute
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  start_hour;
        logic [5:0]  start_minute;
        logic [4:0]  end_hour;
        logic [5:0]  end_minute;
        logic [15:0] tag;
    } t_entry;

    function automatic logic [33:0] key_of(input t_entry e);
        return {e.year, e.month, e.day, e.start_hour, e.start_minute};
    endfunction

    function automatic logic [22:0] date_of(input t_entry e);
        return {e.year, e.month, e.day};
    endfunction

    function automatic logic [10:0] start_of(input t_entry e);
        return {e.start_hour, e.start_minute};
    endfunction

    function automatic logic [10:0] end_of(input t_entry e);
        return {e.end_hour, e.end_minute};
    endfunction

endpackage

/* design/sorted_event_table.sv */
`timescale 1ns / 1ps

// channel | valid      | ready       | payload
// --------+------------+-------------+----------------------------------------------
// in      | i_in_valid | o_in_ready  | i_operation, i_day .. i_tag
// out     | o_out_valid| i_out_ready | o_status, o_position, o_count, o_out_*, o_last
//
// one item at a time; o_in_ready is high only while the sequencer is idle
// insert/delete: a lower-bound binary search through the single table read port,
// the exact key check, on insert the overlap check with the entry before, then
// the shift of the later entries, the new entry's write on insert, and the out beat
// query: each stored entry is read and then its date compared, up to MAX_RESULTS matches
// reset clears the count, the sequencer and out valid; table contents are never read unwritten
// a stalled out beat holds the query scan until it is taken

module sorted_event_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [4:0]  i_day,
    input  logic [3:0]  i_month,
    input  logic [13:0] i_year,
    input  logic [4:0]  i_start_hour,
    input  logic [5:0]  i_start_minute,
    input  logic [4:0]  i_end_hour,
    input  logic [5:0]  i_end_minute,
    input  logic [15:0] i_tag,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [5:0]  o_position,
    output logic [5:0]  o_count,
    output logic [4:0]  o_out_day,
    output logic [3:0]  o_out_month,
    output logic [13:0] o_out_year,
    output logic [4:0]  o_out_start_hour,
    output logic [5:0]  o_out_start_minute,
    output logic [4:0]  o_out_end_hour,
    output logic [5:0]  o_out_end_minute,
    output logic [15:0] o_out_tag,
    output logic        o_last
);

    import set_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,     // issue probe read at mid
        S_SCMP,     // compare probe, narrow the range
        S_FOUND,    // search done, read candidate at lower bound
        S_HIT,      // exact key check on candidate
        S_PREV,     // read the entry before the insert point
        S_OVL,      // overlap check against that entry
        S_SHUP,     // move entries up one slot, top first
        S_PUT,      // write the new entry
        S_SHDN,     // move entries down one slot, bottom first
        S_QRD,      // query: read next entry
        S_QCK,      // query: compare date, pass older match out
        S_EMIT      // final beat
    } t_state;

    t_state            r_state;
    logic [1:0]        r_op;
    t_entry            r_e;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_lo;
    logic [CNT_W-1:0]  r_hi;
    logic [CNT_W-1:0]  r_mid;
    logic [CNT_W-1:0]  r_pos;
    logic [CNT_W-1:0]  r_idx;
    logic [K_W-1:0]    r_k;
    logic              r_wv;
    logic [IDX_W-1:0]  r_wa;

    // staged result; during a query it is the pending match
    t_status           r_res_status;
    logic [CNT_W-1:0]  r_res_pos;
    t_entry            r_res_entry;

    // output register
    logic              r_out_valid;
    t_status           r_out_status;
    logic [CNT_W-1:0]  r_out_pos;
    logic [CNT_W-1:0]  r_out_cnt;
    t_entry            r_out_entry;
    logic              r_out_last;

    t_entry            in_e;
    t_entry            rdata;
    logic [ENTRY_W-1:0] ram_q;
    logic [CNT_W:0]    mid_sum;
    logic [CNT_W-1:0]  mid;
    logic [CNT_W-1:0]  pos_m1;
    logic [CNT_W-1:0]  idx_m1;
    logic              out_free;
    logic              out_load;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    t_entry            wr_data;

    assign in_e = '{year: i_year, month: i_month, day: i_day,
                    start_hour: i_start_hour, start_minute: i_start_minute,
                    end_hour: i_end_hour, end_minute: i_end_minute, tag: i_tag};

    assign rdata    = t_entry'(ram_q);
    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid      = mid_sum[CNT_W:1];
    assign pos_m1   = r_pos - CNT_W'(1);
    assign idx_m1   = r_idx - CNT_W'(1);
    assign out_free = !r_out_valid || i_out_ready;

    // out register takes a beat: final beat, or a pending query match released
    assign out_load = out_free && ((r_state == S_EMIT) ||
                      ((r_state == S_QCK) && (r_k != '0) &&
                       (date_of(rdata) == date_of(r_e))));

    // table port steering
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = mid[IDX_W-1:0];
        wr_en   = 1'b0;
        wr_addr = r_wa;
        wr_data = rdata;
        case (r_state)
            S_SRCH: begin
                rd_en   = r_lo < r_hi;
                rd_addr = mid[IDX_W-1:0];
            end
            S_FOUND: begin
                rd_en   = r_lo < r_count;
                rd_addr = r_lo[IDX_W-1:0];
            end
            S_PREV: begin
                rd_en   = r_pos != '0;
                rd_addr = pos_m1[IDX_W-1:0];
            end
            S_SHUP: begin
                rd_en   = r_idx > r_pos;
                rd_addr = idx_m1[IDX_W-1:0];
                wr_en   = r_wv;
            end
            S_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_pos[IDX_W-1:0];
                wr_data = r_e;
            end
            S_SHDN: begin
                rd_en   = r_idx < r_count;
                rd_addr = r_idx[IDX_W-1:0];
                wr_en   = r_wv;
            end
            S_QRD: begin
                rd_en   = (r_idx < r_count) && (r_k < K_W'(MAX_RESULTS));
                rd_addr = r_idx[IDX_W-1:0];
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    set_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_wv        <= 1'b0;
        end else begin
            r_out_valid <= out_load || (r_out_valid && !i_out_ready);

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_operation;
                        r_e     <= in_e;
                        r_lo    <= '0;
                        r_hi    <= r_count;
                        r_idx   <= '0;
                        r_k     <= '0;
                        r_wv    <= 1'b0;
                        case (i_operation)
                            OP_INSERT: begin
                                r_res_pos   <= '0;
                                r_res_entry <= '0;
                                if (r_count >= CNT_W'(CAPACITY)) begin
                                    r_res_status <= ST_FULL;
                                    r_state      <= S_EMIT;
                                end else if (start_of(in_e) > end_of(in_e)) begin
                                    r_res_status <= ST_BAD_TIME;
                                    r_state      <= S_EMIT;
                                end else begin
                                    r_state <= S_SRCH;
                                end
                            end
                            OP_DELETE: begin
                                r_state <= S_SRCH;
                            end
                            OP_QUERY: begin
                                r_state <= S_QRD;
                            end
                            default: begin
                                // unused code: dropped, no beat
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end

                // lower-bound binary search
                S_SRCH: begin
                    r_mid <= mid;
                    if (r_lo < r_hi) begin
                        r_state <= S_SCMP;
                    end else begin
                        r_state <= S_FOUND;
                    end
                end
                S_SCMP: begin
                    if (key_of(rdata) < key_of(r_e)) begin
                        r_lo <= r_mid + CNT_W'(1);
                    end else begin
                        r_hi <= r_mid;
                    end
                    r_state <= S_SRCH;
                end

                S_FOUND: begin
                    r_pos <= r_lo;
                    if (r_lo < r_count) begin
                        r_state <= S_HIT;
                    end else if (r_op == OP_DELETE) begin
                        r_res_status <= ST_NOT_FOUND;
                        r_res_pos    <= '0;
                        r_res_entry  <= '0;
                        r_state      <= S_EMIT;
                    end else begin
                        r_state <= S_PREV;
                    end
                end

                S_HIT: begin
                    if (key_of(rdata) == key_of(r_e)) begin
                        r_res_pos   <= r_pos;
                        r_res_entry <= rdata;
                        if (r_op == OP_DELETE) begin
                            r_res_status <= ST_OK;
                            r_idx        <= r_pos + CNT_W'(1);
                            r_wv         <= 1'b0;
                            r_state      <= S_SHDN;
                        end else begin
                            r_res_status <= ST_DUP;
                            r_state      <= S_EMIT;
                        end
                    end else if (r_op == OP_DELETE) begin
                        r_res_status <= ST_NOT_FOUND;
                        r_res_pos    <= '0;
                        r_res_entry  <= '0;
                        r_state      <= S_EMIT;
                    end else begin
                        r_state <= S_PREV;
                    end
                end

                S_PREV: begin
                    r_idx <= r_count;
                    r_wv  <= 1'b0;
                    if (r_pos != '0) begin
                        r_state <= S_OVL;
                    end else begin
                        r_state <= S_SHUP;
                    end
                end

                // previous entry on the same date must end by the new start
                S_OVL: begin
                    if (date_of(rdata) == date_of(r_e) && end_of(rdata) > start_of(r_e)) begin
                        r_res_status <= ST_OVERLAP;
                        r_res_pos    <= pos_m1;
                        r_res_entry  <= rdata;
                        r_state      <= S_EMIT;
                    end else begin
                        r_state <= S_SHUP;
                    end
                end

                // read idx-1 now, write it to idx on the next cycle
                S_SHUP: begin
                    if (r_idx > r_pos) begin
                        r_wv  <= 1'b1;
                        r_wa  <= r_idx[IDX_W-1:0];
                        r_idx <= idx_m1;
                    end else begin
                        r_wv    <= 1'b0;
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    r_count      <= r_count + CNT_W'(1);
                    r_res_status <= ST_OK;
                    r_res_pos    <= r_pos;
                    r_res_entry  <= r_e;
                    r_state      <= S_EMIT;
                end

                // read idx now, write it to idx-1 on the next cycle
                S_SHDN: begin
                    if (r_idx < r_count) begin
                        r_wv  <= 1'b1;
                        r_wa  <= idx_m1[IDX_W-1:0];
                        r_idx <= r_idx + CNT_W'(1);
                    end else begin
                        r_wv    <= 1'b0;
                        r_count <= r_count - CNT_W'(1);
                        r_state <= S_EMIT;
                    end
                end

                S_QRD: begin
                    if ((r_idx < r_count) && (r_k < K_W'(MAX_RESULTS))) begin
                        r_state <= S_QCK;
                    end else begin
                        if (r_k == '0) begin
                            r_res_status <= ST_NOT_FOUND;
                            r_res_pos    <= '0;
                            r_res_entry  <= '0;
                        end
                        r_state <= S_EMIT;
                    end
                end

                // a new match releases the pending one as a non-last beat
                S_QCK: begin
                    if (date_of(rdata) == date_of(r_e)) begin
                        if (r_k == '0 || out_free) begin
                            if (r_k != '0) begin
                                r_out_status <= r_res_status;
                                r_out_pos    <= r_res_pos;
                                r_out_cnt    <= r_count;
                                r_out_entry  <= r_res_entry;
                                r_out_last   <= 1'b0;
                            end
                            r_res_status <= ST_OK;
                            r_res_pos    <= r_idx;
                            r_res_entry  <= rdata;
                            r_k          <= r_k + K_W'(1);
                            r_idx        <= r_idx + CNT_W'(1);
                            r_state      <= S_QRD;
                        end
                    end else begin
                        r_idx   <= r_idx + CNT_W'(1);
                        r_state <= S_QRD;
                    end
                end

                S_EMIT: begin
                    if (out_free) begin
                        r_out_status <= r_res_status;
                        r_out_pos    <= r_res_pos;
                        r_out_cnt    <= r_count;
                        r_out_entry  <= r_res_entry;
                        r_out_last   <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready         = (r_state == S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out_status;
    assign o_position         = 6'(r_out_pos);
    assign o_count            = 6'(r_out_cnt);
    assign o_out_day          = r_out_entry.day;
    assign o_out_month        = r_out_entry.month;
    assign o_out_year         = r_out_entry.year;
    assign o_out_start_hour   = r_out_entry.start_hour;
    assign o_out_start_minute = r_out_entry.start_minute;
    assign o_out_end_hour     = r_out_entry.end_hour;
    assign o_out_end_minute   = r_out_entry.end_minute;
    assign o_out_tag          = r_out_entry.tag;
    assign o_last             = r_out_last;

endmodule

/* design/set_ram.sv */
`timescale 1ns / 1ps

module set_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/set_chk.sv */
`timescale 1ns / 1ps

module set_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_status,
    input logic [5:0]  o_position,
    input logic [4:0]  o_out_day,
    input logic [15:0] o_out_tag,
    input logic        o_last
);

    import set_pkg::*;

    // a stalled out beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_position) && $stable(o_out_tag) && $stable(o_last))
        else $error("out beat changed while stalled");

    // every rejection is a single beat
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_last)
        else $error("error beat without last");

    // rejections without an entry report zeros
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL || o_status == ST_BAD_TIME
            || o_status == ST_NOT_FOUND)
            |-> o_position == '0 && o_out_day == '0 && o_out_tag == '0)
        else $error("error beat carries entry data");

    // taking an item ends idle unless it was dropped
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> !o_out_valid || !o_last
            || !o_in_ready)
        else $error("beat appeared while idle after accept");

endmodule

bind sorted_event_table set_chk u_set_chk (.*);
